// ===== hdl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants of the page bitmap allocator
// Request kinds, status codes, register indexes and the zero-search result.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int NUM_PAGES_DEF  = 4096;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int ADDR_W   = 32;   // address and bitmap word width
  localparam int CNT_W    = 13;   // page_count register width
  localparam int STAT_W   = 2;
  localparam int OUT_W    = 40;   // page_address + status, padded to bytes
  localparam int BIT_W    = 5;    // bit index within a bitmap word

  // request kinds (s_tuser)
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM    = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTALLOC = 2'd3;

  // configuration register indexes
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } find_t;

endpackage

// ===== hdl/pba_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// pba_bitmap_ram: used-bit store, one 32-bit word per 32 pages
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pba_bitmap_ram #(
  parameter int WORDS = 128,
  parameter int WA_W  = 7
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [WA_W-1:0]            waddr,
  input  logic [pba_pkg::ADDR_W-1:0] wdata,
  input  logic                       re,
  input  logic [WA_W-1:0]            raddr,
  output logic [pba_pkg::ADDR_W-1:0] rdata
);

  logic [pba_pkg::ADDR_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pba_zero_find.sv =====
// ----------------------------------------------------------------------------
// pba_zero_find: lowest free page within one bitmap word
// Bits at or beyond the page limit count as used.
// ----------------------------------------------------------------------------
module pba_zero_find #(
  parameter int WA_W  = 7,
  parameter int LIM_W = 13
) (
  input  logic [pba_pkg::ADDR_W-1:0] word,
  input  logic [WA_W-1:0]            word_idx,
  input  logic [LIM_W-1:0]           limit,
  output pba_pkg::find_t             result
);

  logic [31:0] first_pg;
  logic [31:0] lim32;
  logic [31:0] rem;
  logic [31:0] mask;
  logic [31:0] free_bits;

  always_comb begin
    first_pg = 32'({word_idx, 5'b0});
    lim32    = 32'(limit);
    rem      = lim32 - first_pg;
    if (lim32 <= first_pg) begin
      mask = '0;
    end else if (rem >= 32'd32) begin
      mask = '1;
    end else begin
      mask = (32'd1 << rem[4:0]) - 32'd1;
    end
    free_bits = ~word & mask;
  end

  // priority encoder, lowest index wins
  always_comb begin
    result.found = |free_bits;
    result.idx   = '0;
    for (int i = 31; i >= 0; i--) begin
      if (free_bits[i]) begin
        result.idx = 5'(i);
      end
    end
  end

endmodule

// ===== hdl/page_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top: bitmap page-frame allocator
// Flow: a free request passes S_FRD, S_FCHK and S_DONE (only S_DONE when out
//   of range); an allocate request streams bitmap words through the finder in
//   S_SCAN, then S_DONE (only S_DONE when no pages are managed). A stalled
//   result holds S_DONE. The single bitmap read port sets the scan rate.
// Throughput: one request at a time; a new request is taken while the
//   previous result still waits in the output register.
// Reset: synchronous; a clearing pass over every bitmap word zeroes the
//   bitmap, s_tready stays low meanwhile. Config writes are taken anytime.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top #(
  parameter int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,   // 256..65536
  parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF   // power of two
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pba_pkg::ADDR_W-1:0] cfg_data,
  // request stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [pba_pkg::ADDR_W-1:0] s_tdata,   // [31:0] free_address
  input  logic                       s_tuser,   // [0] cmd
  // result stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [pba_pkg::OUT_W-1:0]  m_tdata    // [31:0] page_address, [33:32] status
);

  localparam int WORDS = (NUM_PAGES + 31) / 32;
  localparam int WA_W  = $clog2(WORDS);
  localparam int WC_W  = $clog2(WORDS + 1);
  localparam int PG_W  = WA_W + pba_pkg::BIT_W;
  localparam int LIM_W = $clog2(NUM_PAGES + 1);
  localparam int SHIFT = $clog2(PAGE_BYTES);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // post-reset bitmap clear
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;  // allocate: stream words through finder
  localparam logic [2:0] S_FRD   = 3'd3;  // free: read the word
  localparam logic [2:0] S_FCHK  = 3'd4;  // free: check and clear bit
  localparam logic [2:0] S_DONE  = 3'd5;  // hand result to output register

  logic [2:0]                  state;
  logic [pba_pkg::ADDR_W-1:0]  base_address;
  logic [pba_pkg::CNT_W-1:0]   page_count;

  logic [WC_W-1:0]             cnt;        // clear / scan read counter
  logic                        pend;       // rdata holds word pend_word
  logic [WA_W-1:0]             pend_word;
  logic [PG_W-1:0]             page_idx;   // hit page or page to free
  logic [pba_pkg::STAT_W-1:0]  res_status;
  logic                        res_alloc;

  // page limit: min(page_count, NUM_PAGES) rounded down to 8
  logic [31:0]      cnt_ext;
  logic [31:0]      clamp;
  logic [LIM_W-1:0] limit;
  logic [WC_W-1:0]  nwords;

  always_comb begin
    cnt_ext = 32'(page_count);
    clamp   = (cnt_ext > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : cnt_ext;
    limit   = LIM_W'(clamp & ~32'd7);
    nwords  = WC_W'((32'(limit) + 32'd31) >> 5);
  end

  // free request address decode
  logic [31:0] offset;
  logic [31:0] page_off;
  logic        in_range;

  always_comb begin
    offset   = s_tdata - base_address;
    page_off = offset >> SHIFT;
    in_range = page_off < 32'(limit);
  end

  // bitmap memory
  logic                        ram_we;
  logic [WA_W-1:0]             ram_waddr;
  logic [pba_pkg::ADDR_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [WA_W-1:0]             ram_raddr;
  logic [pba_pkg::ADDR_W-1:0]  ram_rdata;

  pba_bitmap_ram #(
    .WORDS (WORDS),
    .WA_W  (WA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // search unit, fed one word per cycle during the scan
  pba_pkg::find_t find;

  pba_zero_find #(
    .WA_W  (WA_W),
    .LIM_W (LIM_W)
  ) u_find (
    .word     (ram_rdata),
    .word_idx (pend_word),
    .limit    (limit),
    .result   (find)
  );

  logic scan_last;
  logic bit_used;

  assign scan_last = (WC_W'(pend_word) + WC_W'(1)) == nwords;
  assign bit_used  = ram_rdata[page_idx[pba_pkg::BIT_W-1:0]];
  assign s_tready  = (state == S_IDLE);

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_word;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cnt[WA_W-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[WA_W-1:0];
        ram_wdata = '0;
      end
      S_SCAN: begin
        ram_re = (cnt < nwords);
        // mark the hit page used
        if (pend && find.found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (32'd1 << find.idx);
        end
      end
      S_FRD: begin
        ram_re    = 1'b1;
        ram_raddr = page_idx[PG_W-1:pba_pkg::BIT_W];
      end
      S_FCHK: begin
        ram_waddr = page_idx[PG_W-1:pba_pkg::BIT_W];
        ram_we    = bit_used;
        ram_wdata = ram_rdata & ~(32'd1 << page_idx[pba_pkg::BIT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  logic [pba_pkg::ADDR_W-1:0] res_addr;

  assign res_addr = (res_alloc && res_status == pba_pkg::ST_OK)
                  ? base_address + 32'({page_idx, {SHIFT{1'b0}}})
                  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      pend         <= 1'b0;
      m_tvalid     <= 1'b0;
      base_address <= '0;
      page_count   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pba_pkg::REG_BASE:  base_address <= cfg_data;
          pba_pkg::REG_COUNT: page_count   <= cfg_data[pba_pkg::CNT_W-1:0];
        endcase
      end

      // in S_DONE a ready sink always reloads the output register
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + WC_W'(1);
          if (cnt == WC_W'(WORDS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            res_alloc <= (s_tuser == pba_pkg::CMD_ALLOC);
            cnt       <= '0;
            pend      <= 1'b0;
            if (s_tuser == pba_pkg::CMD_ALLOC) begin
              if (nwords == '0) begin
                res_status <= pba_pkg::ST_NOMEM;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else if (!in_range) begin
              res_status <= pba_pkg::ST_RANGE;
              state      <= S_DONE;
            end else begin
              page_idx <= PG_W'(page_off);
              state    <= S_FRD;
            end
          end
        end
        S_SCAN: begin
          if (cnt < nwords) begin
            cnt       <= cnt + WC_W'(1);
            pend      <= 1'b1;
            pend_word <= cnt[WA_W-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (find.found) begin
              page_idx   <= {pend_word, find.idx};
              res_status <= pba_pkg::ST_OK;
              state      <= S_DONE;
            end else if (scan_last) begin
              res_status <= pba_pkg::ST_NOMEM;
              state      <= S_DONE;
            end
          end
        end
        S_FRD: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          res_status <= bit_used ? pba_pkg::ST_OK : pba_pkg::ST_NOTALLOC;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, res_status, res_addr};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/pba_checker.sv =====
// ----------------------------------------------------------------------------
// pba_checker: port-level checks of the page bitmap allocator
// Watches the request and result streams of the top level.
// ----------------------------------------------------------------------------
module pba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [pba_pkg::OUT_W-1:0]  m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // bitmap clear runs after reset
  a_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken during clear");

  // error results carry a zero address
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != pba_pkg::ST_OK |-> m_tdata[31:0] == '0)
    else $error("nonzero address on error");

endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb_page_bitmap_allocator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator_top: self-checking bench for the page allocator
// A queue-fed driver sends allocate and free requests in random bursts, a
// monitor predicts each accepted request against a local bitmap and checks
// every result in order. Registers are rewritten between phases when idle.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator_top;

  localparam int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF;
  localparam int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF;

  // receiver ready patterns
  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    logic                       cmd;
    logic [pba_pkg::ADDR_W-1:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [pba_pkg::ADDR_W-1:0] page_address;
    logic [pba_pkg::STAT_W-1:0] status;
  } page_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = pba_pkg::REG_BASE;
  logic [pba_pkg::ADDR_W-1:0] cfg_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [pba_pkg::ADDR_W-1:0] s_tdata = '0;                  // [31:0] free_address
  logic                       s_tuser = pba_pkg::CMD_ALLOC;  // [0] cmd
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [pba_pkg::OUT_W-1:0]  m_tdata;   // [31:0] page_address, [33:32] status

  page_bitmap_allocator_top #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  page_req_t    queued_requests[$];   // filled by the sequence, drained by the driver
  page_result_t pending_results[$];   // predicted results, oldest first
  int unsigned  issued_cnt  = 0;      // requests queued so far
  int unsigned  checked_cnt = 0;      // results matched against a prediction
  int unsigned  mismatches  = 0;

  // allocator model: bitmap plus its own copy of the two registers
  bit                         page_used[NUM_PAGES];
  logic [pba_pkg::ADDR_W-1:0] model_base  = '0;
  logic [pba_pkg::CNT_W-1:0]  model_count = '0;

  // what the sequence believes is configured, used only to aim free addresses
  logic [pba_pkg::ADDR_W-1:0] gen_base  = '0;
  int unsigned                gen_limit = 0;

  // pages visible to the allocator: clamp, then round down to a byte of bits
  function automatic int unsigned pages_managed(logic [pba_pkg::CNT_W-1:0] cnt);
    int unsigned n;
    n = (cnt > NUM_PAGES) ? NUM_PAGES : cnt;
    return n & ~32'd7;
  endfunction

  // Applies one request to the model bitmap and returns the expected result.
  function automatic page_result_t predict_page_result(logic cmd,
                                                       logic [pba_pkg::ADDR_W-1:0] addr);
    page_result_t               r;
    int unsigned                lim;
    int unsigned                i;
    int unsigned                pg;
    logic [pba_pkg::ADDR_W-1:0] offs;
    bit                         found;
    r.page_address = '0;
    r.status       = pba_pkg::ST_OK;
    lim = pages_managed(model_count);
    if (cmd == pba_pkg::CMD_ALLOC) begin
      // lowest free page wins
      found = 1'b0;
      i = 0;
      while (i < lim && !found) begin
        if (!page_used[i]) begin
          found = 1'b1;
          page_used[i] = 1'b1;
          r.page_address = model_base + i * PAGE_BYTES;   // wraps mod 2^32
        end
        i++;
      end
      if (!found) r.status = pba_pkg::ST_NOMEM;
    end else begin
      // an unaligned address frees the page that holds it
      offs = addr - model_base;
      pg   = offs / PAGE_BYTES;
      if (pg >= lim) begin
        r.status = pba_pkg::ST_RANGE;
      end else if (!page_used[pg]) begin
        r.status = pba_pkg::ST_NOTALLOC;
      end else begin
        page_used[pg] = 1'b0;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps between them
  // --------------------------------------------------------------------------
  page_req_t   next_req;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (queued_requests.size() != 0) begin
        next_req = queued_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_req.addr;
        s_tuser  <= next_req.cmd;
        if (burst_left <= 1) begin
          // a third of the bursts run straight into the next one
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern changes at random intervals; once, after 600
  // results, it holds ready low so the block backs up into s_tready
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode     = RX_OPEN;
  int unsigned mode_left   = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  int unsigned results_taken = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) results_taken <= results_taken + 1;
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (!hold_done && results_taken == 600) begin
        hold_left <= 400;
        hold_done <= 1'b1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= !m_tready;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: tracks register writes, predicts on accept, checks results
  // --------------------------------------------------------------------------
  page_result_t got;
  page_result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == pba_pkg::REG_BASE) model_base = cfg_data;
        else model_count = cfg_data[pba_pkg::CNT_W-1:0];
      end
      // check before predicting: the result leaving now is never for the
      // request entering now
      if (m_tvalid && m_tready) begin
        got.page_address = m_tdata[pba_pkg::ADDR_W-1:0];
        got.status       = m_tdata[pba_pkg::ADDR_W +: pba_pkg::STAT_W];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result addr %h status %0d",
                     $realtime, got.page_address, got.status);
        end else begin
          want = pending_results.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (got.page_address !== want.page_address || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected addr %h status %0d, got addr %h status %0d",
                       $realtime, want.page_address, want.status,
                       got.page_address, got.status);
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_page_result(s_tuser, s_tdata));
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  task automatic queue_request(logic cmd, logic [pba_pkg::ADDR_W-1:0] addr);
    page_req_t r;
    r.cmd  = cmd;
    r.addr = addr;
    queued_requests.push_back(r);
    issued_cnt++;
  endtask

  // both registers back to back, then the sequence's view is updated
  task automatic write_regs(logic [pba_pkg::ADDR_W-1:0] base,
                            logic [pba_pkg::ADDR_W-1:0] count_word);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pba_pkg::REG_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= pba_pkg::REG_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_base  = base;
    gen_limit = pages_managed(count_word[pba_pkg::CNT_W-1:0]);
  endtask

  // sender pauses here until every predicted result has come back
  task automatic wait_idle();
    while (checked_cnt != issued_cnt) @(posedge clk);
  endtask

  // Frees lean toward low pages, which lowest-first allocation keeps busy;
  // some land just past the limit and some anywhere at all.
  task automatic queue_random_requests(int unsigned n, int unsigned alloc_pct);
    logic                       cmd;
    logic [pba_pkg::ADDR_W-1:0] addr;
    int unsigned                pick;
    int unsigned                span;
    int unsigned                idx;
    repeat (n) begin
      addr = $urandom;
      cmd  = ($urandom_range(1, 100) <= alloc_pct) ? pba_pkg::CMD_ALLOC : pba_pkg::CMD_FREE;
      if (cmd == pba_pkg::CMD_FREE && gen_limit != 0) begin
        pick = $urandom_range(0, 99);
        span = (gen_limit > 64) ? 64 : gen_limit;
        if (pick < 85) begin
          if (pick < 40) idx = $urandom_range(0, span - 1);
          else if (pick < 70) idx = $urandom_range(0, gen_limit - 1);
          else idx = gen_limit + $urandom_range(0, 40);
          addr = gen_base + idx * PAGE_BYTES;
          if ($urandom_range(0, 1) == 1) addr = addr + $urandom_range(0, PAGE_BYTES - 1);
        end
      end
      queue_request(cmd, addr);
    end
  endtask

  task automatic run_phase(logic [pba_pkg::ADDR_W-1:0] base,
                           logic [pba_pkg::ADDR_W-1:0] count_word,
                           int unsigned n, int unsigned alloc_pct);
    write_regs(base, count_word);
    queue_random_requests(n, alloc_pct);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [pba_pkg::ADDR_W-1:0] top_base;
    top_base = 32'hFFFF_F000;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: nothing managed
    queue_request(pba_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    queue_request(pba_pkg::CMD_FREE, 32'h0000_0000);
    queue_request(pba_pkg::CMD_FREE, 32'hFFFF_FFFF);
    wait_idle();

    // eight pages at the top of the address space, page one wraps to zero;
    // junk above bit 12 of the count must be dropped
    write_regs(top_base, 32'hFFFF_E008);
    for (int k = 0; k < 9; k++)   // last one finds the map full
      queue_request(pba_pkg::CMD_ALLOC, (k % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
    queue_request(pba_pkg::CMD_FREE, top_base + 3 * PAGE_BYTES + 32'hABC);   // unaligned
    queue_request(pba_pkg::CMD_FREE, top_base + 3 * PAGE_BYTES);             // already free
    queue_request(pba_pkg::CMD_FREE, top_base + 8 * PAGE_BYTES);             // one past limit
    queue_request(pba_pkg::CMD_FREE, top_base - 1);                          // below base
    queue_request(pba_pkg::CMD_FREE, 32'hFFFF_FFFF);                         // page zero
    queue_request(pba_pkg::CMD_FREE, 32'h0000_0000);                         // page one
    repeat (4) queue_request(pba_pkg::CMD_ALLOC, $urandom);
    wait_idle();

    // count above the bitmap size clamps to the full map
    write_regs(32'h0000_0000, 32'h0000_1FFF);
    queue_request(pba_pkg::CMD_ALLOC, $urandom);
    queue_request(pba_pkg::CMD_FREE, (NUM_PAGES - 1) * PAGE_BYTES);
    queue_request(pba_pkg::CMD_FREE, NUM_PAGES * PAGE_BYTES);
    wait_idle();

    // random phases; the bitmap carries over, so shrinking and regrowing
    // the count exposes pages that were hidden
    run_phase($urandom, 64, 200, 70);
    run_phase(32'hFFFF_FFFF, 9, 100, 50);
    run_phase(32'h0000_0000, ($urandom & 32'hFFFF_E000) | 32'h1FFF, 200, 80);
    run_phase($urandom & 32'hFFFF_F000, 520, 560, 95);   // fills up, long hold lands here
    run_phase($urandom, 16, 150, 50);
    run_phase($urandom, 7, 30, 50);
    run_phase($urandom, NUM_PAGES, 300, 50);
    run_phase(32'h0000_0000, 0, 20, 50);

    // let any stray result surface
    repeat (NUM_PAGES / 32 + 8) @(posedge clk);
    if (mismatches == 0 && checked_cnt == issued_cnt) begin
      $display("tb_page_bitmap_allocator_top passed");
    end else begin
      $display("tb_page_bitmap_allocator_top failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_page_bitmap_allocator_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pba_pkg.sv
hdl/pba_bitmap_ram.sv
hdl/pba_zero_find.sv
hdl/page_bitmap_allocator_top.sv
hdl/pba_checker.sv
tb/tb_page_bitmap_allocator_top.sv
